### hw/rtl/pngu_pkg.sv
// Shared constants, types and a helper function for the PNG scanline unfilter.
package pngu_pkg;

  localparam int MAX_LINE_BYTES  = 4096;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
  localparam int COL_W  = ADDR_W + 1;
  localparam int LINE_W = 13;
  localparam int BPP_W  = 4;
  localparam int PSEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int HIST_W = 8 * MAX_PIXEL_BYTES;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LINE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // One data byte, classified by the front end.
  typedef struct packed {
    logic [7:0]        raw;
    logic [ADDR_W-1:0] idx;
    filter_t           filter;
    logic              first_row;
    logic              row_start;
    logic              row_last;
  } pngu_item_t;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

### hw/rtl/pngu_if.sv
// Handshake channel interfaces: input stream, result stream, configuration writes.
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       image_start;

  modport source (output valid, output in_byte, output image_start, input ready);
  modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       row_last;

  modport source (output valid, output out_byte, output row_last, input ready);
  modport sink   (input valid, input out_byte, input row_last, output ready);
endinterface

interface pngu_cfg_if import pngu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pngu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pngu_front.sv
// Front end: takes stream bytes, tracks row position, tags data bytes for the back end.
module pngu_front import pngu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pngu_in_if.sink           stream,
  input  logic [COL_W-1:0]  line_len,
  input  logic              q_full,
  output logic              push,
  output pngu_item_t        item
);

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  filter_t          filter_kind;
  filter_t          filter_kind_next;
  logic             first_row;
  logic             first_row_next;
  logic [COL_W-1:0] col_cur;
  logic             first_cur;
  logic             accept;
  logic             is_data;
  logic             last;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;

  // image start forces a filter byte
  assign col_cur   = stream.image_start ? '0 : col;
  assign first_cur = stream.image_start ? 1'b1 : first_row;
  assign is_data   = (col_cur != '0);
  assign last      = (col_cur >= line_len);

  assign push           = accept && is_data;
  assign item.raw       = stream.in_byte;
  assign item.idx       = ADDR_W'(col_cur - COL_W'(1));
  assign item.filter    = filter_kind;
  assign item.first_row = first_cur;
  assign item.row_start = (col_cur == COL_W'(1));
  assign item.row_last  = last;

  always_comb begin
    col_next         = col;
    filter_kind_next = filter_kind;
    first_row_next   = first_row;
    if (accept) begin
      first_row_next = first_cur;
      if (!is_data) begin
        filter_kind_next = (stream.in_byte > 8'd4) ? FILT_NONE : filter_t'(stream.in_byte[2:0]);
        col_next         = COL_W'(1);
      end else if (last) begin
        col_next       = '0;
        first_row_next = 1'b0;
      end else begin
        col_next = col_cur + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      filter_kind <= FILT_NONE;
      first_row   <= 1'b1;
    end else begin
      col         <= col_next;
      filter_kind <= filter_kind_next;
      first_row   <= first_row_next;
    end
  end

endmodule

### hw/rtl/pngu_queue.sv
// Small register FIFO between front and back end.
module pngu_queue import pngu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pngu_item_t din,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output pngu_item_t head
);

  pngu_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/pngu_back.sv
// Back end: line buffer read, filter reconstruction, line buffer write, result register.
module pngu_back import pngu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pngu_item_t        q_head,
  output logic              pop,
  input  logic [PSEL_W-1:0] pix_sel,
  pngu_out_if.source        result
);

  logic              s2_valid;
  pngu_item_t        s2_item;
  logic              s2_fwd;
  logic [7:0]        s2_fwd_byte;
  logic              s2_adv;
  logic [7:0]        ram_rdata;
  logic [HIST_W-1:0] left_hist;
  logic [HIST_W-1:0] ul_hist;
  logic [HIST_W-1:0] left_eff;
  logic [HIST_W-1:0] ul_eff;
  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;
  logic [7:0]        val;

  assign s2_adv = s2_valid && (!result.valid || result.ready);
  assign pop    = !q_empty && (!s2_valid || s2_adv);

  // read on pop, write when the item leaves stage 2
  pngu_ram #(.WIDTH(8), .DEPTH(MAX_LINE_BYTES)) u_prior_row (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s2_item.idx),
    .wdata (val),
    .re    (pop),
    .raddr (q_head.idx),
    .rdata (ram_rdata)
  );

  assign left_eff = s2_item.row_start ? '0 : left_hist;
  assign ul_eff   = s2_item.row_start ? '0 : ul_hist;
  assign a        = left_eff[pix_sel*8 +: 8];
  assign c        = ul_eff[pix_sel*8 +: 8];
  assign b        = s2_item.first_row ? 8'd0 : (s2_fwd ? s2_fwd_byte : ram_rdata);
  assign avg_sum  = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (s2_item.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign val = s2_item.raw + pred;

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item     <= q_head;
      // same byte being written this cycle: RAM returns old data
      s2_fwd      <= s2_adv && (s2_item.idx == q_head.idx);
      s2_fwd_byte <= val;
    end
    if (s2_adv) begin
      left_hist       <= (left_eff << 8) | HIST_W'(val);
      ul_hist         <= (ul_eff << 8) | HIST_W'(b);
      result.out_byte <= val;
      result.row_last <= s2_item.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter (None/Sub/Up/Average/Paeth reconstruction).
//
//   channel   dir   payload                 request meaning
//   stream    in    in_byte, image_start    one filtered stream byte
//   result    out   out_byte, row_last      one reconstructed data byte
//   cfg       in    index, data             one register write
//
// Throughput is one byte per cycle while the result side takes each result; the limit
// is the Sub/Paeth loop through the left-neighbor history register in the back end.
// An accepted data byte passes into the queue, then a queue pop with line buffer
// read into stage 2, then reconstruction into the result register. Filter bytes
// produce no result.
// Reset is synchronous; the line buffer has no reset and its read data is unused on
// the first row of an image. The queue lets the input keep flowing while the result
// side stalls, until its four entries fill; cfg is always ready.
module png_scanline_unfilter import pngu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pngu_in_if.sink     stream,
  pngu_out_if.source  result,
  pngu_cfg_if.sink    cfg
);

  // config registers
  logic [LINE_W-1:0] line_bytes;
  logic [BPP_W-1:0]  bytes_per_pixel;

  // effective (clamped) config
  logic [COL_W-1:0]  line_len;
  logic [PSEL_W-1:0] pix_sel;

  // front/back coupling
  logic              push;
  pngu_item_t        front_item;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  pngu_item_t        q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes      <= LINE_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LINE_BYTES:      line_bytes      <= cfg.data;
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data[BPP_W-1:0];
        default:             ;
      endcase
    end
  end

  // zero length acts as one; oversize clamps to the buffer depth
  always_comb begin
    if (line_bytes == '0) begin
      line_len = COL_W'(1);
    end else if (32'(line_bytes) > MAX_LINE_BYTES) begin
      line_len = COL_W'(MAX_LINE_BYTES);
    end else begin
      line_len = COL_W'(line_bytes);
    end
  end

  // byte lane of the left neighbor: pixel size minus one, clamped
  always_comb begin
    if (bytes_per_pixel == '0) begin
      pix_sel = '0;
    end else if (32'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
      pix_sel = PSEL_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      pix_sel = PSEL_W'(bytes_per_pixel - BPP_W'(1));
    end
  end

  pngu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .stream   (stream),
    .line_len (line_len),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  pngu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (q_head)
  );

  pngu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .pix_sel (pix_sel),
    .result  (result)
  );

endmodule
